// File: rtl/mmu_pkg.sv
// Shared types and constants of the translation unit.
package mmu_pkg;
	localparam int TlbDepth  = 16;
	localparam int MaxPages  = 1024;
	localparam int FrameBits = 16;

	localparam logic [5:0] RstLogicalBits = 6'd16;
	localparam logic [4:0] RstPageShift   = 5'd12;
	localparam logic [4:0] RstTlbInUse    = 5'd16;

	typedef enum logic [2:0] {
		OP_READ  = 3'd0,
		OP_WRITE = 3'd1,
		OP_MAP   = 3'd2,
		OP_UNMAP = 3'd3,
		OP_FLUSH = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_ADDR  = 2'd1,
		ST_NOT_ALLOC = 2'd2,
		ST_BEYOND    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_LOGICAL_BITS = 2'd0,
		CFG_PAGE_SHIFT   = 2'd1,
		CFG_TLB_IN_USE   = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_OUT
	} fsm_t;
endpackage

// File: rtl/mmu_if.sv
// Valid/ready channel interfaces for operation and result items.
interface mmu_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] vaddr;
	logic [15:0] new_frame;
	modport source (output valid, operation, vaddr, new_frame, input ready);
	modport sink (input valid, operation, vaddr, new_frame, output ready);
endinterface

interface mmu_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] phys_addr;
	logic        tlb_hit;
	logic        page_referenced;
	logic        page_dirty;
	modport source (output valid, status, phys_addr, tlb_hit, page_referenced, page_dirty,
		input ready);
	modport sink (input valid, status, phys_addr, tlb_hit, page_referenced, page_dirty,
		output ready);
endinterface

// File: rtl/mmu_pt_mem.sv
// Page table memory: valid, referenced, dirty and frame per page in one word.
module mmu_pt_mem #(
	parameter int MAX_PAGES  = mmu_pkg::MaxPages,
	parameter int FRAME_BITS = mmu_pkg::FrameBits,
	localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	output logic                  init_done,
	input  logic [AW-1:0]         rd_addr,
	output logic                  rd_valid,
	output logic [FRAME_BITS-1:0] rd_frame,
	output logic                  rd_ref,
	output logic                  rd_dirty,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic                  wr_valid,
	input  logic [FRAME_BITS-1:0] wr_frame,
	input  logic                  wr_ref,
	input  logic                  wr_dirty
);
	localparam int DW = FRAME_BITS + 3;

	logic [DW-1:0] mem [MAX_PAGES];
	logic [DW-1:0] rd_word_q;
	logic [AW-1:0] clr_addr_q;
	logic          clr_busy_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [DW-1:0] mem_wd;

	// after reset every entry is zeroed, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(MAX_PAGES - 1)) clr_busy_q <= 1'b0;
		end
	end

	always_comb begin
		mem_we = clr_busy_q | wr_en;
		mem_wa = clr_busy_q ? clr_addr_q : wr_addr;
		mem_wd = clr_busy_q ? '0 : {wr_valid, wr_ref, wr_dirty, wr_frame};
	end

	always_ff @(posedge clk) begin
		rd_word_q <= mem[rd_addr];
		if (mem_we) mem[mem_wa] <= mem_wd;
	end

	assign init_done = !clr_busy_q;
	assign rd_valid  = rd_word_q[DW-1];
	assign rd_ref    = rd_word_q[DW-2];
	assign rd_dirty  = rd_word_q[DW-3];
	assign rd_frame  = rd_word_q[FRAME_BITS-1:0];
endmodule

// File: rtl/mmu_tlb.sv
// Fully associative TLB with timestamp LRU replacement.
module mmu_tlb #(
	parameter int TLB_DEPTH  = mmu_pkg::TlbDepth,
	parameter int FRAME_BITS = mmu_pkg::FrameBits,
	localparam int IW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [4:0]            in_use,
	input  logic [31:0]           page,
	output logic                  hit,
	output logic [FRAME_BITS-1:0] hit_frame,
	input  logic                  touch,
	input  logic                  fill,
	input  logic [FRAME_BITS-1:0] fill_frame,
	input  logic                  inval,
	input  logic                  flush
);
	localparam int NL = 1 << IW;

	logic [TLB_DEPTH-1:0]  valid_q;
	logic [31:0]           page_q  [TLB_DEPTH];
	logic [FRAME_BITS-1:0] frame_q [TLB_DEPTH];
	logic [63:0]           stamp_q [TLB_DEPTH];
	logic [63:0]           ctr_q;
	logic [IW-1:0]         hit_idx, victim, free_idx;
	logic [6:0]            n_used;
	logic                  found_free;
	logic [63:0]           node_stamp [2*NL];
	logic [IW-1:0]         node_idx [2*NL];

	always_comb begin
		n_used = (in_use == 5'd0) ? 7'd1 : {2'b0, in_use};
		if (n_used > 7'(TLB_DEPTH)) n_used = 7'(TLB_DEPTH);
		hit = 1'b0;
		hit_idx = '0;
		for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
			if (7'(i) < n_used && valid_q[i] && page_q[i] == page) begin
				hit = 1'b1;
				hit_idx = IW'(i);
			end
		end
		hit_frame = frame_q[hit_idx];
		found_free = 1'b0;
		free_idx = '0;
		for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
			if (7'(i) < n_used && !valid_q[i]) begin
				found_free = 1'b1;
				free_idx = IW'(i);
			end
		end
		// min tree over stamps; the left (lower) index wins a tie
		node_stamp[0] = '0;
		node_idx[0] = '0;
		for (int i = 0; i < TLB_DEPTH; i++) begin
			node_idx[NL+i] = IW'(i);
			node_stamp[NL+i] = (7'(i) < n_used) ? stamp_q[i] : '1;
		end
		for (int i = TLB_DEPTH; i < NL; i++) begin
			node_idx[NL+i] = IW'(i);
			node_stamp[NL+i] = '1;
		end
		for (int l = NL - 1; l >= 1; l--) begin
			if (node_stamp[2*l+1] < node_stamp[2*l]) begin
				node_stamp[l] = node_stamp[2*l+1];
				node_idx[l] = node_idx[2*l+1];
			end else begin
				node_stamp[l] = node_stamp[2*l];
				node_idx[l] = node_idx[2*l];
			end
		end
		victim = found_free ? free_idx : node_idx[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ctr_q   <= '0;
		end else if (flush) begin
			valid_q <= '0;
		end else if (touch && hit) begin
			ctr_q <= ctr_q + 64'd1;
		end else if (fill) begin
			valid_q[victim] <= 1'b1;
			ctr_q <= ctr_q + 64'd1;
		end else if (inval && hit) begin
			valid_q[hit_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!flush && touch && hit) stamp_q[hit_idx] <= ctr_q;
		else if (!flush && fill) begin
			page_q[victim]  <= page;
			frame_q[victim] <= fill_frame;
			stamp_q[victim] <= ctr_q;
		end
	end
endmodule

// File: rtl/mmu_translate_tlb_lru_core.sv
// Top level: translation unit with LRU TLB in front of a page table.
// One operation (read, write, map, unmap, flush) is taken at a time and gives one
// result item. After reset the page table is swept clear one entry per cycle, so no
// item is accepted until the sweep is done. An item then passes through S_IDLE,
// where the accepting cycle drives the page-table address into the registered
// memory read, S_EXEC, which searches the TLB and writes back page and TLB state,
// and S_OUT, which presents the result. The next item can be accepted the cycle
// after the result is taken; a stalled result holds the input off.
module mmu_translate_tlb_lru_core #(
	parameter int TLB_DEPTH  = mmu_pkg::TlbDepth,
	parameter int MAX_PAGES  = mmu_pkg::MaxPages,
	parameter int FRAME_BITS = mmu_pkg::FrameBits
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [5:0] cfg_data,
	mmu_req_if.sink    req,
	mmu_rsp_if.source  rsp
);
	localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

	mmu_pkg::fsm_t state_q, state_d;
	logic [5:0]  lab_q;
	logic [4:0]  shift_q, inuse_q;
	logic [2:0]  op_q;
	logic [31:0] va_q;
	logic [15:0] nf_q;
	logic [31:0] page;
	logic        beyond, bad_addr;
	logic        pt_ready;
	logic        pt_v, pt_r, pt_d;
	logic [FRAME_BITS-1:0] pt_f, frame_use;
	logic        tlb_hit_w, touch, fill, inval, flush;
	logic        wr_en, wr_v, wr_r, wr_d;
	logic [FRAME_BITS-1:0] wr_f;
	logic [1:0]  st_d, st_q;
	logic [31:0] pa_d, pa_q;
	logic        hit_d, hit_q, ref_d, ref_q, dirty_d, dirty_q;
	logic [63:0] pa_wide, off_mask, max_addr;
	logic [5:0]  bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lab_q   <= mmu_pkg::RstLogicalBits;
			shift_q <= mmu_pkg::RstPageShift;
			inuse_q <= mmu_pkg::RstTlbInUse;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mmu_pkg::CFG_LOGICAL_BITS: lab_q   <= cfg_data;
				mmu_pkg::CFG_PAGE_SHIFT:   shift_q <= cfg_data[4:0];
				mmu_pkg::CFG_TLB_IN_USE:   inuse_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign page = req.valid && state_q == mmu_pkg::S_IDLE ? req.vaddr >> shift_q
		: va_q >> shift_q;

	mmu_pt_mem #(.MAX_PAGES(MAX_PAGES), .FRAME_BITS(FRAME_BITS)) u_pt (
		.clk, .arst_n, .init_done(pt_ready),
		.rd_addr(page[AW-1:0]),
		.rd_valid(pt_v), .rd_frame(pt_f), .rd_ref(pt_r), .rd_dirty(pt_d),
		.wr_en, .wr_addr(page[AW-1:0]), .wr_valid(wr_v), .wr_frame(wr_f),
		.wr_ref(wr_r), .wr_dirty(wr_d)
	);

	mmu_tlb #(.TLB_DEPTH(TLB_DEPTH), .FRAME_BITS(FRAME_BITS)) u_tlb (
		.clk, .arst_n, .in_use(inuse_q), .page,
		.hit(tlb_hit_w), .hit_frame(frame_use),
		.touch, .fill, .fill_frame(pt_f), .inval, .flush
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mmu_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q <= req.operation;
			va_q <= req.vaddr;
			nf_q <= req.new_frame;
		end
		if (state_q == mmu_pkg::S_EXEC) begin
			st_q <= st_d; pa_q <= pa_d; hit_q <= hit_d;
			ref_q <= ref_d; dirty_q <= dirty_d;
		end
	end

	always_comb begin
		bits = lab_q > 6'd32 ? 6'd32 : lab_q;
		max_addr = (64'd1 << bits) - 64'd1;
		bad_addr = {32'd0, va_q} > max_addr;
		beyond = page >= 32'(MAX_PAGES);
		off_mask = (64'd1 << shift_q) - 64'd1;
		state_d = state_q;
		req.ready = 1'b0;
		rsp.valid = 1'b0;
		touch = 1'b0; fill = 1'b0; inval = 1'b0; flush = 1'b0;
		wr_en = 1'b0; wr_v = pt_v; wr_f = pt_f; wr_r = pt_r; wr_d = pt_d;
		st_d = mmu_pkg::ST_OK; pa_d = '0; hit_d = 1'b0; ref_d = 1'b0; dirty_d = 1'b0;
		pa_wide = '0;
		unique case (state_q)
			mmu_pkg::S_IDLE: begin
				// held off while the page table is being cleared
				req.ready = pt_ready;
				if (req.valid && pt_ready) state_d = mmu_pkg::S_EXEC;
			end
			mmu_pkg::S_EXEC: begin
				state_d = mmu_pkg::S_OUT;
				case (op_q) inside
					mmu_pkg::OP_READ, mmu_pkg::OP_WRITE: begin
						if (bad_addr) st_d = mmu_pkg::ST_BAD_ADDR;
						else begin
							touch = 1'b1;
							hit_d = tlb_hit_w;
							if (beyond) st_d = mmu_pkg::ST_BEYOND;
							else if (!pt_v) begin
								st_d = mmu_pkg::ST_NOT_ALLOC;
								ref_d = pt_r; dirty_d = pt_d;
							end else begin
								fill = !tlb_hit_w;
								wr_en = 1'b1; wr_r = 1'b1;
								wr_d = pt_d | (op_q == mmu_pkg::OP_WRITE);
								pa_wide = ({32'd0, 32'(tlb_hit_w ? frame_use : pt_f)}
									<< shift_q) | ({32'd0, va_q} & off_mask);
								pa_d = pa_wide[31:0];
								ref_d = 1'b1; dirty_d = wr_d;
							end
						end
					end
					mmu_pkg::OP_MAP: begin
						if (beyond) st_d = mmu_pkg::ST_BEYOND;
						else begin
							if (!pt_v) begin
								wr_en = 1'b1; wr_v = 1'b1; wr_r = 1'b0; wr_d = 1'b0;
								wr_f = FRAME_BITS'({16'd0, nf_q});
							end
							pa_wide = ({32'd0, 32'(pt_v ? pt_f : wr_f)} << shift_q)
								| ({32'd0, va_q} & off_mask);
							pa_d = pa_wide[31:0];
							ref_d = wr_r; dirty_d = wr_d;
						end
					end
					mmu_pkg::OP_UNMAP: begin
						if (beyond) st_d = mmu_pkg::ST_BEYOND;
						else begin
							if (!pt_v) st_d = mmu_pkg::ST_NOT_ALLOC;
							else begin
								wr_en = 1'b1; wr_v = 1'b0; inval = 1'b1;
							end
							ref_d = pt_r; dirty_d = pt_d;
						end
					end
					mmu_pkg::OP_FLUSH: flush = 1'b1;
					default: ;
				endcase
			end
			mmu_pkg::S_OUT: begin
				rsp.valid = 1'b1;
				if (rsp.ready) state_d = mmu_pkg::S_IDLE;
			end
			default: state_d = mmu_pkg::S_IDLE;
		endcase
		// out-of-range pages must not touch the table
		if (beyond) wr_en = 1'b0;
	end

	assign rsp.status          = st_q;
	assign rsp.phys_addr       = pa_q;
	assign rsp.tlb_hit         = hit_q;
	assign rsp.page_referenced = ref_q;
	assign rsp.page_dirty      = dirty_q;
endmodule

// File: dv/tb_mmu_translate_tlb_lru_core.sv
// Self-checking testbench for the translation unit: TLB/page-table predictor and scoreboard.
module tb_mmu_translate_tlb_lru_core;
	localparam int          RandItems  = 1350;
	localparam int          CycleLimit = 300000;
	localparam logic [2:0]  OP_RSVD_A  = 3'd5;
	localparam logic [2:0]  OP_RSVD_B  = 3'd6;
	localparam logic [2:0]  OP_RSVD_C  = 3'd7;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] va;
		logic [15:0] nf;
	} xlate_req_t;

	typedef struct packed {
		mmu_pkg::status_t status;
		logic [31:0]      pa;
		logic             hit;
		logic             refd;
		logic             dirty;
	} xlate_rsp_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [5:0] cfg_data;

	mmu_req_if req ();
	mmu_rsp_if rsp ();

	mmu_translate_tlb_lru_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.req     (req.sink),
		.rsp     (rsp.source)
	);

	// shadow of the unit's state and registers
	logic [5:0]  sh_bits;
	logic [4:0]  sh_shift;
	logic [4:0]  sh_inuse;
	logic        tlb_vld [mmu_pkg::TlbDepth];
	logic [31:0] tlb_pg [mmu_pkg::TlbDepth];
	logic [15:0] tlb_frm [mmu_pkg::TlbDepth];
	logic [63:0] tlb_stamp [mmu_pkg::TlbDepth];
	logic [63:0] lru_clock;
	logic        pt_vld [mmu_pkg::MaxPages];
	logic [15:0] pt_frm [mmu_pkg::MaxPages];
	logic        pt_ref [mmu_pkg::MaxPages];
	logic        pt_dirty [mmu_pkg::MaxPages];

	xlate_req_t pending_ops[$];
	xlate_rsp_t expected_rsps[$];
	int send_idle_pct;
	int rsp_stall_pct;
	int mismatches = 0;
	int cycles = 0;

	function automatic int entries_searched();
		if (sh_inuse == 0) return 1;
		if (sh_inuse > mmu_pkg::TlbDepth) return mmu_pkg::TlbDepth;
		return int'(sh_inuse);
	endfunction

	function automatic logic [31:0] phys_of(logic [15:0] frame, logic [31:0] va);
		logic [63:0] off_mask;
		logic [63:0] pa;
		off_mask = (64'd1 << sh_shift) - 64'd1;
		pa = ({48'd0, frame} << sh_shift) | ({32'd0, va} & off_mask);
		return pa[31:0];
	endfunction

	function automatic xlate_rsp_t translate(xlate_req_t it);
		xlate_rsp_t r;
		logic [31:0] page;
		logic [63:0] max_addr;
		logic [63:0] oldest;
		logic [15:0] frame;
		int n;
		int victim;
		int bits;
		int hit_idx;
		r = '0;
		r.status = mmu_pkg::ST_OK;
		page = it.va >> sh_shift;
		n = entries_searched();
		case (it.op) inside
			mmu_pkg::OP_READ, mmu_pkg::OP_WRITE: begin
				bits = (sh_bits > 32) ? 32 : int'(sh_bits);
				max_addr = (64'd1 << bits) - 64'd1;
				if ({32'd0, it.va} > max_addr) begin
					r.status = mmu_pkg::ST_BAD_ADDR;
				end else begin
					hit_idx = -1;
					frame = '0;
					for (int i = 0; i < n; i++) begin
						if (hit_idx < 0 && tlb_vld[i] && tlb_pg[i] == page) hit_idx = i;
					end
					if (hit_idx >= 0) begin
						frame = tlb_frm[hit_idx];
						tlb_stamp[hit_idx] = lru_clock;
						lru_clock++;
						r.hit = 1'b1;
					end
					if (page >= mmu_pkg::MaxPages) begin
						r.status = mmu_pkg::ST_BEYOND;
					end else if (!pt_vld[page]) begin
						r.status = mmu_pkg::ST_NOT_ALLOC;
						r.refd = pt_ref[page];
						r.dirty = pt_dirty[page];
					end else begin
						if (hit_idx < 0) begin
							frame = pt_frm[page];
							victim = 0;
							oldest = '1;
							for (int i = 0; i < n; i++) begin
								if (!tlb_vld[i]) begin
									victim = i;
									break;
								end
								if (tlb_stamp[i] < oldest) begin
									oldest = tlb_stamp[i];
									victim = i;
								end
							end
							tlb_pg[victim] = page;
							tlb_frm[victim] = frame;
							tlb_vld[victim] = 1'b1;
							tlb_stamp[victim] = lru_clock;
							lru_clock++;
						end
						pt_ref[page] = 1'b1;
						if (it.op == mmu_pkg::OP_WRITE) pt_dirty[page] = 1'b1;
						r.pa = phys_of(frame, it.va);
						r.refd = pt_ref[page];
						r.dirty = pt_dirty[page];
					end
				end
			end
			mmu_pkg::OP_MAP: begin
				if (page >= mmu_pkg::MaxPages) begin
					r.status = mmu_pkg::ST_BEYOND;
				end else begin
					if (!pt_vld[page]) begin
						pt_vld[page] = 1'b1;
						pt_frm[page] = it.nf;
						pt_ref[page] = 1'b0;
						pt_dirty[page] = 1'b0;
					end
					r.pa = phys_of(pt_frm[page], it.va);
					r.refd = pt_ref[page];
					r.dirty = pt_dirty[page];
				end
			end
			mmu_pkg::OP_UNMAP: begin
				if (page >= mmu_pkg::MaxPages) begin
					r.status = mmu_pkg::ST_BEYOND;
				end else begin
					if (!pt_vld[page]) begin
						r.status = mmu_pkg::ST_NOT_ALLOC;
					end else begin
						pt_vld[page] = 1'b0;
						for (int i = 0; i < n; i++) begin
							if (tlb_vld[i] && tlb_pg[i] == page) begin
								tlb_vld[i] = 1'b0;
								break;
							end
						end
					end
					r.refd = pt_ref[page];
					r.dirty = pt_dirty[page];
				end
			end
			mmu_pkg::OP_FLUSH: begin
				for (int i = 0; i < mmu_pkg::TlbDepth; i++) tlb_vld[i] = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// mostly a small pool of pages so the TLB thrashes and hits
	function automatic xlate_req_t random_op();
		xlate_req_t it;
		int bits;
		int sel;
		logic [63:0] span;
		logic [63:0] page;
		logic [31:0] off_mask;
		bits = (sh_bits > 32) ? 32 : int'(sh_bits);
		span = (bits <= sh_shift) ? 64'd1 : (64'd1 << (bits - sh_shift));
		off_mask = 32'((64'd1 << sh_shift) - 64'd1);
		sel = $urandom_range(99);
		if (sel < 35) it.op = mmu_pkg::OP_READ;
		else if (sel < 60) it.op = mmu_pkg::OP_WRITE;
		else if (sel < 82) it.op = mmu_pkg::OP_MAP;
		else if (sel < 94) it.op = mmu_pkg::OP_UNMAP;
		else if (sel < 97) it.op = mmu_pkg::OP_FLUSH;
		else it.op = 3'($urandom_range(OP_RSVD_A, OP_RSVD_C));
		sel = $urandom_range(99);
		if (sel < 70) page = $urandom_range(0, int'((span < 24) ? span : 24) - 1);
		else if (sel < 88) page = $urandom_range(0, int'((span < 1100) ? span : 1100) - 1);
		else page = {32'd0, $urandom} >> sh_shift;
		it.va = 32'(page << sh_shift) | ($urandom & off_mask);
		it.nf = 16'($urandom);
		return it;
	endfunction

	task automatic write_reg(mmu_pkg::cfg_idx_t idx, logic [5:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			mmu_pkg::CFG_LOGICAL_BITS: sh_bits = val;
			mmu_pkg::CFG_PAGE_SHIFT: sh_shift = val[4:0];
			mmu_pkg::CFG_TLB_IN_USE: sh_inuse = val[4:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_ops.size() != 0 || req.valid || expected_rsps.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic push_op(logic [2:0] op, logic [31:0] va, logic [15:0] nf);
		pending_ops.push_back('{op: op, va: va, nf: nf});
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("mmu_translate_tlb_lru_core: mismatch");
			$finish;
		end
	end

	// driver: predict on acceptance, then present the next item or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.operation <= '0;
			req.vaddr <= '0;
			req.new_frame <= '0;
		end else begin
			if (req.valid && req.ready)
				expected_rsps.push_back(translate('{op: req.operation, va: req.vaddr,
					nf: req.new_frame}));
			if (!req.valid || req.ready) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					xlate_req_t it;
					it = pending_ops.pop_front();
					req.valid <= 1'b1;
					req.operation <= it.op;
					req.vaddr <= it.va;
					req.new_frame <= it.nf;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp.ready <= 1'b0;
		else rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			xlate_rsp_t got;
			xlate_rsp_t want;
			got = '{status: mmu_pkg::status_t'(rsp.status), pa: rsp.phys_addr,
				hit: rsp.tlb_hit, refd: rsp.page_referenced, dirty: rsp.page_dirty};
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result item: %p", got);
			end else begin
				want = expected_rsps.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	initial begin
		logic [5:0] phase_cfg [10][3];
		int per_phase;
		phase_cfg = '{
			'{6'd32, 6'd0,  6'd1},  '{6'd10, 6'd2,  6'd4},  '{6'd0,  6'd16, 6'd0},
			'{6'd63, 6'd31, 6'd31}, '{6'd20, 6'd8,  6'd16}, '{6'd32, 6'd10, 6'd3},
			'{6'd24, 6'd16, 6'd8},  '{6'd32, 6'd12, 6'd17}, '{6'd5,  6'd1,  6'd2},
			'{6'd1,  6'd0,  6'd15}};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		sh_bits = mmu_pkg::RstLogicalBits;
		sh_shift = mmu_pkg::RstPageShift;
		sh_inuse = mmu_pkg::RstTlbInUse;
		lru_clock = '0;
		for (int i = 0; i < mmu_pkg::TlbDepth; i++) tlb_vld[i] = 1'b0;
		for (int i = 0; i < mmu_pkg::MaxPages; i++) begin
			pt_vld[i] = 1'b0;
			pt_ref[i] = 1'b0;
			pt_dirty[i] = 1'b0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed pass at reset settings
		push_op(mmu_pkg::OP_MAP, 32'h0000_0000, 16'hFFFF);
		push_op(mmu_pkg::OP_READ, 32'h0000_0000, 16'h0000);
		push_op(mmu_pkg::OP_READ, 32'h0000_0FFF, 16'h0000);
		push_op(mmu_pkg::OP_WRITE, 32'h0000_0ABC, 16'h0000);
		push_op(mmu_pkg::OP_MAP, 32'h0000_0123, 16'h1234);
		push_op(mmu_pkg::OP_READ, 32'h0001_0000, 16'h0000);
		push_op(mmu_pkg::OP_READ, 32'hFFFF_FFFF, 16'h0000);
		push_op(mmu_pkg::OP_READ, 32'h0000_5000, 16'h0000);
		push_op(mmu_pkg::OP_UNMAP, 32'h0000_5000, 16'h0000);
		push_op(mmu_pkg::OP_MAP, 32'h0000_F000, 16'h0001);
		push_op(mmu_pkg::OP_WRITE, 32'h0000_FFFF, 16'h0000);
		push_op(mmu_pkg::OP_MAP, 32'hFFFF_FFFF, 16'hA5A5);
		push_op(mmu_pkg::OP_UNMAP, 32'hFFFF_FFFF, 16'h0000);
		push_op(mmu_pkg::OP_FLUSH, 32'h0000_0000, 16'h0000);
		push_op(mmu_pkg::OP_READ, 32'h0000_0001, 16'h0000);
		push_op(mmu_pkg::OP_UNMAP, 32'h0000_0000, 16'h0000);
		push_op(mmu_pkg::OP_READ, 32'h0000_0000, 16'h0000);
		push_op(mmu_pkg::OP_WRITE, 32'h0000_F001, 16'h0000);
		push_op(OP_RSVD_A, 32'hFFFF_FFFF, 16'hFFFF);
		push_op(OP_RSVD_B, 32'h0000_0000, 16'h0000);
		push_op(OP_RSVD_C, 32'h8000_0000, 16'h8000);
		wait_idle();

		per_phase = RandItems / 10;
		for (int p = 0; p < 10; p++) begin
			write_reg(mmu_pkg::CFG_LOGICAL_BITS, phase_cfg[p][0]);
			write_reg(mmu_pkg::CFG_PAGE_SHIFT, phase_cfg[p][1]);
			write_reg(mmu_pkg::CFG_TLB_IN_USE, phase_cfg[p][2]);
			case (p % 4)
				0: begin send_idle_pct = 0; rsp_stall_pct = 0; end
				1: begin send_idle_pct = 45; rsp_stall_pct = 0; end
				2: begin send_idle_pct = 0; rsp_stall_pct = 45; end
				default: begin send_idle_pct = 38; rsp_stall_pct = 38; end
			endcase
			for (int k = 0; k < per_phase; k++) pending_ops.push_back(random_op());
			// sender holds off here until every result of the phase is back
			wait_idle();
		end

		repeat (10) @(negedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0) begin
			$display("mmu_translate_tlb_lru_core: match");
		end else begin
			$display("mmu_translate_tlb_lru_core: mismatch");
		end
		$finish;
	end
endmodule

// File: filelist.f
rtl/mmu_pkg.sv
rtl/mmu_if.sv
rtl/mmu_pt_mem.sv
rtl/mmu_tlb.sv
rtl/mmu_translate_tlb_lru_core.sv
dv/tb_mmu_translate_tlb_lru_core.sv
